/* rtl/pcsm_pkg.sv */
// Package for the P-code stack machine: opcode and arithmetic sub-operation codes
// and the fixed limits of the machine. Depends on nothing.
package pcsm_pkg;

    localparam logic [3:0] OP_LIT = 4'd0;
    localparam logic [3:0] OP_OPR = 4'd1;
    localparam logic [3:0] OP_LOD = 4'd2;
    localparam logic [3:0] OP_STO = 4'd3;
    localparam logic [3:0] OP_CAL = 4'd4;
    localparam logic [3:0] OP_INC = 4'd5;
    localparam logic [3:0] OP_JMP = 4'd6;
    localparam logic [3:0] OP_JPC = 4'd7;
    localparam logic [3:0] OP_OUT = 4'd8;
    localparam logic [3:0] OP_IN  = 4'd9;

    localparam logic signed [31:0] OPR_RET = 32'sd0;
    localparam logic signed [31:0] OPR_NEG = 32'sd1;
    localparam logic signed [31:0] OPR_ADD = 32'sd2;
    localparam logic signed [31:0] OPR_SUB = 32'sd3;
    localparam logic signed [31:0] OPR_MUL = 32'sd4;
    localparam logic signed [31:0] OPR_DIV = 32'sd5;
    localparam logic signed [31:0] OPR_ODD = 32'sd6;
    localparam logic signed [31:0] OPR_MOD = 32'sd7;
    localparam logic signed [31:0] OPR_EQL = 32'sd8;
    localparam logic signed [31:0] OPR_NEQ = 32'sd9;
    localparam logic signed [31:0] OPR_LSS = 32'sd10;
    localparam logic signed [31:0] OPR_LEQ = 32'sd11;
    localparam logic signed [31:0] OPR_GTR = 32'sd12;
    localparam logic signed [31:0] OPR_GEQ = 32'sd13;

    localparam logic [9:0] CALL_DEPTH_MAX = 10'd1023;
    localparam int PC_SPACE = 1024;

endpackage

/* rtl/pcsm_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module pcsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/pcode_stack_machine_step_top.sv */
// P-code stack machine that executes one instruction per input item.
// Depends on pcsm_pkg and pcsm_ram.
//
// After reset the block clears the whole stack memory and takes no item during that time.
// Each item then goes from acceptance through a walk of the static links for lod, sto and
// cal, a check, two stack reads, execution, a bit-serial division for div and mod, and the
// stack writes (three words for cal) to a loaded result register. A halted machine goes
// straight to its result. The pace is set by the single stack memory, which gives one read
// and one write per cycle with a registered read, and by the one-bit-per-cycle divider.
module pcode_stack_machine_step_top #(
    parameter int STACK_DEPTH    = 1024,
    parameter int MAX_LEVEL_DIFF = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_opcode,
    input  logic [3:0]  i_level_diff,
    input  logic [31:0] i_operand,
    input  logic [31:0] i_read_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_next_pc,
    output logic        o_out_valid,
    output logic [31:0] o_out_value,
    output logic        o_halted,
    output logic        o_fault
);
    import pcsm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = AW + 1;
    localparam int LW = $clog2(MAX_LEVEL_DIFF + 1);
    localparam int PC_LIMIT = (STACK_DEPTH < PC_SPACE) ? STACK_DEPTH : PC_SPACE;
    localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);
    localparam logic signed [32:0] LIMIT_S = 33'(PC_LIMIT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STACK_DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WALK, S_WALKW, S_CHK, S_RD1, S_RD2,
        S_EXEC, S_DIV, S_DFIN, S_WR, S_OUT
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_clr;
    logic [3:0] r_op;
    logic signed [31:0] r_m;
    logic [31:0] r_rd;
    logic [LW-1:0] r_n;
    logic signed [31:0] r_b;
    logic [SW-1:0] r_sp;
    logic [AW-1:0] r_fb;
    logic [9:0] r_depth;
    logic [9:0] r_pc;
    logic r_halt, r_fault;
    logic [31:0] r_d0, r_d1;
    logic [31:0] r_w0, r_w1, r_w2;
    logic [AW-1:0] r_wa;
    logic [1:0] r_wn, r_wi;
    logic [31:0] r_dvd, r_rem, r_dvs;
    logic [4:0] r_dcnt;
    logic r_qneg, r_rneg, r_ismod;
    logic [9:0] r_res_pc;
    logic r_res_ov, r_res_halt, r_res_fault;
    logic [31:0] r_res_val;
    logic r_o_valid, r_o_ov, r_o_halt, r_o_fault;
    logic [9:0] r_o_pc;
    logic [31:0] r_o_val;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;

    logic signed [33:0] sp34, fb34, b34, m34, addr_a, inc_a, a0, a1;
    logic a_ok, walk_ok, inc_ok, pre_fault, is_bin;
    logic [LW-1:0] lev_cl;

    logic ex_fault, ex_stop, ex_div, ex_ov;
    logic signed [32:0] ex_npc;
    logic [SW-1:0] n_sp;
    logic [AW-1:0] n_fb;
    logic [9:0] n_depth;
    logic [1:0] ex_wn;
    logic [AW-1:0] ex_wa;
    logic [31:0] ex_w0, ex_w1, ex_w2, ex_val, prod;
    logic signed [33:0] nb34;
    logic [10:0] pc_inc;
    logic [32:0] div_t;
    logic div_ge;

    pcsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign sp34 = $signed({{(34 - SW){1'b0}}, r_sp});
    assign fb34 = $signed({{(34 - AW){1'b0}}, r_fb});
    assign b34 = {{2{r_b[31]}}, r_b};
    assign m34 = {{2{r_m[31]}}, r_m};
    assign addr_a = b34 - 34'sd1 + m34;
    assign inc_a = sp34 + m34;
    assign a_ok = (addr_a >= 34'sd0) && (addr_a < DEPTH_S);
    assign walk_ok = (b34 >= 34'sd1) && (b34 <= DEPTH_S);
    assign inc_ok = (inc_a >= 34'sd0) && (inc_a <= DEPTH_S);
    assign is_bin = (r_m >= OPR_ADD) && (r_m <= OPR_GEQ) && (r_m != OPR_ODD);
    assign lev_cl = (32'(i_level_diff) > MAX_LEVEL_DIFF) ? LW'(MAX_LEVEL_DIFF)
                                                         : LW'(i_level_diff);
    assign pc_inc = 11'(r_pc) + 11'd1;
    assign prod = 32'(r_d0 * r_d1);
    assign nb34 = {{2{r_d0[31]}}, r_d0};
    assign div_t = {r_rem, r_dvd[31]};
    assign div_ge = div_t >= {1'b0, r_dvs};

    always_comb begin
        pre_fault = 1'b0;
        a0 = sp34 - 34'sd1;
        a1 = sp34 - 34'sd1;
        unique case (r_op)
            OP_LIT, OP_IN: pre_fault = sp34 >= DEPTH_S;
            OP_OPR: begin
                if (r_m == OPR_RET) begin
                    pre_fault = !((fb34 >= 34'sd1) && (fb34 + 34'sd1 < DEPTH_S));
                    a0 = fb34;
                    a1 = fb34 + 34'sd1;
                end else if (r_m == OPR_NEG || r_m == OPR_ODD) begin
                    pre_fault = sp34 < 34'sd1;
                end else if (is_bin) begin
                    pre_fault = sp34 < 34'sd2;
                    a0 = sp34 - 34'sd2;
                end
            end
            OP_LOD: begin
                pre_fault = (sp34 >= DEPTH_S) || !a_ok;
                a0 = addr_a;
            end
            OP_STO: pre_fault = (sp34 < 34'sd1) || !a_ok;
            OP_CAL: pre_fault = (r_depth >= CALL_DEPTH_MAX) || (sp34 + 34'sd2 >= DEPTH_S);
            OP_INC: pre_fault = !inc_ok;
            OP_JPC, OP_OUT: pre_fault = sp34 < 34'sd1;
            default: pre_fault = 1'b0;
        endcase
    end

    always_comb begin
        ex_fault = 1'b0;
        ex_stop = 1'b0;
        ex_div = 1'b0;
        ex_ov = 1'b0;
        ex_val = '0;
        ex_npc = $signed({22'd0, pc_inc});
        n_sp = r_sp;
        n_fb = r_fb;
        n_depth = r_depth;
        ex_wn = 2'd0;
        ex_wa = r_sp[AW-1:0];
        ex_w0 = '0;
        ex_w1 = '0;
        ex_w2 = '0;
        unique case (r_op)
            OP_LIT, OP_IN: begin
                ex_wn = 2'd1;
                ex_w0 = (r_op == OP_LIT) ? r_m : r_rd;
                n_sp = r_sp + 1'b1;
            end
            OP_OPR: begin
                if (r_m == OPR_RET) begin
                    if (!((nb34 >= 34'sd0) && (nb34 < DEPTH_S))) begin
                        ex_fault = 1'b1;
                    end else begin
                        n_sp = SW'(r_fb) - 1'b1;
                        ex_npc = {r_d1[31], r_d1};
                        n_fb = nb34[AW-1:0];
                        if (r_depth == 10'd0) begin
                            ex_stop = 1'b1;
                        end else begin
                            n_depth = r_depth - 1'b1;
                        end
                    end
                end else if (r_m == OPR_NEG || r_m == OPR_ODD) begin
                    ex_wn = 2'd1;
                    ex_wa = AW'(r_sp - 1'b1);
                    ex_w0 = (r_m == OPR_NEG) ? 32'(-r_d0) : {31'd0, r_d0[0]};
                end else if (is_bin) begin
                    ex_wn = 2'd1;
                    ex_wa = AW'(r_sp - 2'd2);
                    n_sp = r_sp - 1'b1;
                    if (r_m == OPR_ADD) ex_w0 = r_d0 + r_d1;
                    else if (r_m == OPR_SUB) ex_w0 = r_d0 - r_d1;
                    else if (r_m == OPR_MUL) ex_w0 = prod;
                    else if (r_m == OPR_EQL) ex_w0 = {31'd0, r_d0 == r_d1};
                    else if (r_m == OPR_NEQ) ex_w0 = {31'd0, r_d0 != r_d1};
                    else if (r_m == OPR_LSS) ex_w0 = {31'd0, $signed(r_d0) < $signed(r_d1)};
                    else if (r_m == OPR_LEQ) ex_w0 = {31'd0, $signed(r_d0) <= $signed(r_d1)};
                    else if (r_m == OPR_GTR) ex_w0 = {31'd0, $signed(r_d0) > $signed(r_d1)};
                    else if (r_m == OPR_GEQ) ex_w0 = {31'd0, $signed(r_d0) >= $signed(r_d1)};
                    else begin
                        ex_fault = r_d1 == 32'd0;
                        ex_div = 1'b1;
                    end
                end
            end
            OP_LOD: begin
                ex_wn = 2'd1;
                ex_w0 = r_d0;
                n_sp = r_sp + 1'b1;
            end
            OP_STO: begin
                ex_wn = 2'd1;
                ex_wa = addr_a[AW-1:0];
                ex_w0 = r_d0;
                n_sp = r_sp - 1'b1;
            end
            OP_CAL: begin
                ex_wn = 2'd3;
                ex_w0 = r_b;
                ex_w1 = 32'(r_fb);
                ex_w2 = 32'(pc_inc);
                n_fb = AW'(r_sp + 1'b1);
                ex_npc = {r_m[31], r_m};
                n_depth = r_depth + 1'b1;
            end
            OP_INC: n_sp = inc_a[SW-1:0];
            OP_JMP: ex_npc = {r_m[31], r_m};
            OP_JPC: begin
                n_sp = r_sp - 1'b1;
                if (r_d0 == 32'd0) ex_npc = {r_m[31], r_m};
            end
            OP_OUT: begin
                n_sp = r_sp - 1'b1;
                ex_ov = 1'b1;
                ex_val = r_d0;
            end
            default: ex_npc = $signed({22'd0, pc_inc});
        endcase
        if (ex_npc < 33'sd0 || ex_npc >= LIMIT_S) begin
            ex_stop = 1'b1;
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        unique case (r_state)
            S_WALK: ram_raddr = AW'(b34 - 34'sd1);
            S_CHK: ram_raddr = a0[AW-1:0];
            S_RD1: ram_raddr = a1[AW-1:0];
            default: ram_raddr = a0[AW-1:0];
        endcase
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_WR && r_wi != r_wn) begin
            ram_we = 1'b1;
            ram_waddr = AW'(r_wa + AW'(r_wi));
            unique case (r_wi)
                2'd0: ram_wdata = r_w0;
                2'd1: ram_wdata = r_w1;
                default: ram_wdata = r_w2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_sp <= '0;
            r_fb <= AW'(1);
            r_depth <= '0;
            r_pc <= '0;
            r_halt <= 1'b0;
            r_fault <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ADDR) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_opcode;
                        r_m <= i_operand;
                        r_rd <= i_read_value;
                        r_b <= 32'(r_fb);
                        r_n <= (i_opcode == OP_LOD || i_opcode == OP_STO ||
                                i_opcode == OP_CAL) ? lev_cl : '0;
                        if (r_halt) begin
                            r_res_pc <= r_pc;
                            r_res_ov <= 1'b0;
                            r_res_val <= '0;
                            r_res_halt <= 1'b1;
                            r_res_fault <= r_fault;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_n == '0) begin
                        r_state <= S_CHK;
                    end else if (!walk_ok) begin
                        r_halt <= 1'b1;
                        r_fault <= 1'b1;
                        r_res_pc <= r_pc;
                        r_res_ov <= 1'b0;
                        r_res_val <= '0;
                        r_res_halt <= 1'b1;
                        r_res_fault <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WALKW;
                    end
                end
                S_WALKW: begin
                    r_b <= ram_rdata;
                    r_n <= LW'(r_n - 1'b1);
                    r_state <= S_WALK;
                end
                S_CHK: begin
                    if (pre_fault) begin
                        r_halt <= 1'b1;
                        r_fault <= 1'b1;
                        r_res_pc <= r_pc;
                        r_res_ov <= 1'b0;
                        r_res_val <= '0;
                        r_res_halt <= 1'b1;
                        r_res_fault <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_d0 <= ram_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_d1 <= ram_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (ex_fault) begin
                        r_halt <= 1'b1;
                        r_fault <= 1'b1;
                        r_res_pc <= r_pc;
                        r_res_ov <= 1'b0;
                        r_res_val <= '0;
                        r_res_halt <= 1'b1;
                        r_res_fault <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_sp <= n_sp;
                        r_fb <= n_fb;
                        r_depth <= n_depth;
                        r_pc <= ex_npc[9:0];
                        r_halt <= ex_stop;
                        r_res_pc <= ex_npc[9:0];
                        r_res_ov <= ex_ov;
                        r_res_val <= ex_val;
                        r_res_halt <= ex_stop;
                        r_res_fault <= 1'b0;
                        r_wa <= ex_wa;
                        r_wn <= ex_wn;
                        r_wi <= 2'd0;
                        r_w0 <= ex_w0;
                        r_w1 <= ex_w1;
                        r_w2 <= ex_w2;
                        r_dvd <= r_d0[31] ? 32'(-r_d0) : r_d0;
                        r_dvs <= r_d1[31] ? 32'(-r_d1) : r_d1;
                        r_rem <= '0;
                        r_dcnt <= '0;
                        r_qneg <= r_d0[31] ^ r_d1[31];
                        r_rneg <= r_d0[31];
                        r_ismod <= r_m == OPR_MOD;
                        r_state <= ex_div ? S_DIV : S_WR;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? 32'(div_t - {1'b0, r_dvs}) : div_t[31:0];
                    r_dvd <= {r_dvd[30:0], div_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'd31) r_state <= S_DFIN;
                end
                S_DFIN: begin
                    if (r_ismod) begin
                        r_w0 <= r_rneg ? 32'(-r_rem) : r_rem;
                    end else begin
                        r_w0 <= r_qneg ? 32'(-r_dvd) : r_dvd;
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_wi == r_wn) begin
                        r_state <= S_OUT;
                    end else begin
                        r_wi <= r_wi + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_pc <= r_res_pc;
                        r_o_ov <= r_res_ov;
                        r_o_val <= r_res_val;
                        r_o_halt <= r_res_halt;
                        r_o_fault <= r_res_fault;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_o_valid;
    assign o_next_pc = r_o_pc;
    assign o_out_valid = r_o_ov;
    assign o_out_value = r_o_val;
    assign o_halted = r_o_halt;
    assign o_fault = r_o_fault;

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped");
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> r_halt)
        else $error("fault without halt");
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sp34 <= DEPTH_S)
        else $error("stack pointer beyond depth");
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_o_valid)
        else $error("result during clearing pass");
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_WR))
        else $error("stack write outside write states");
`endif
endmodule

/* dv/tb_pcode_stack_machine_step_top.sv */
// Testbench for pcode_stack_machine_step_top: a directed instruction table, then random
// programs that keep the machine running, then one halting sequence. Depends on pcsm_pkg
// and the RTL of the block; results are checked against a predictor kept here.
`timescale 1ns / 100ps

module tb_pcode_stack_machine_step_top;
    import pcsm_pkg::*;

    localparam int STACK_WORDS = 1024;
    localparam int LEVEL_CAP = 15;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1880;
    localparam logic [3:0] OP_UNUSED = 4'd12;
    localparam logic [31:0] OPR_UNUSED = 32'd20;

    typedef struct packed {
        logic [9:0]  pc;
        logic        ov;
        logic [31:0] oval;
        logic        hlt;
        logic        flt;
    } t_step_res;

    typedef struct {
        logic [3:0]  op;
        logic [3:0]  lev;
        logic [31:0] m;
        logic [31:0] rd;
        bit          typed;
        logic [9:0]  pc;
        logic        ov;
        logic [31:0] oval;
    } t_instr_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_opcode;
    logic [3:0]  i_level_diff;
    logic [31:0] i_operand;
    logic [31:0] i_read_value;
    logic        o_valid;
    logic        i_ready;
    logic [9:0]  o_next_pc;
    logic        o_out_valid;
    logic [31:0] o_out_value;
    logic        o_halted;
    logic        o_fault;

    logic [31:0] stack_mem [STACK_WORDS];
    longint      stack_ptr;
    longint      base_ptr;
    int          depth_now;
    int          pc_now;
    bit          halted_now;
    bit          faulted_now;

    t_step_res   pending_results[$];
    t_instr_row  directed_rows[$];
    int          mismatch_count;
    int          results_seen;
    int          items_sent;
    int          cycle_count;
    bit          rx_hold_req;
    bit          tx_idle_on;

    pcode_stack_machine_step_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_level_diff(i_level_diff), .i_operand(i_operand),
        .i_read_value(i_read_value), .o_valid(o_valid), .i_ready(i_ready),
        .o_next_pc(o_next_pc), .o_out_valid(o_out_valid), .o_out_value(o_out_value),
        .o_halted(o_halted), .o_fault(o_fault)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic bit in_range(input longint idx);
        return idx >= 0 && idx < STACK_WORDS;
    endfunction

    function automatic bit walk_links(input int levels, output longint b);
        longint x;
        int n;
        x = base_ptr;
        n = levels > LEVEL_CAP ? LEVEL_CAP : levels;
        b = 0;
        repeat (n) begin
            if (!in_range(x - 1)) return 1'b0;
            x = longint'($signed(stack_mem[x - 1]));
        end
        b = x;
        return 1'b1;
    endfunction

    function automatic t_step_res predict_step(input bit commit, input logic [3:0] op,
                                               input logic [3:0] lev, input logic [31:0] m,
                                               input logic [31:0] rd);
        t_step_res   r;
        longint      ms, npc, a, b, nb, nsp, nfb;
        logic [31:0] x, y, v, outv;
        bit          bad, stop, wrote;
        int          nw, ndepth;
        longint      wa[3];
        logic [31:0] wd[3];
        ms = longint'($signed(m));
        npc = pc_now + 1;
        nsp = stack_ptr;
        nfb = base_ptr;
        ndepth = depth_now;
        bad = 0; stop = 0; wrote = 0; nw = 0; outv = '0; v = '0;
        if (halted_now) begin
            r = {pc_now[9:0], 1'b0, 32'd0, 1'b1, faulted_now};
            return r;
        end
        case (op)
            OP_LIT, OP_IN: begin
                if (stack_ptr >= STACK_WORDS) bad = 1;
                else begin
                    wa[0] = stack_ptr; wd[0] = (op == OP_LIT) ? m : rd; nw = 1;
                    nsp = stack_ptr + 1;
                end
            end
            OP_OPR: begin
                if (m == OPR_RET) begin
                    if (base_ptr < 1 || !in_range(base_ptr + 1)) bad = 1;
                    else begin
                        nb = longint'($signed(stack_mem[base_ptr]));
                        if (!in_range(nb)) bad = 1;
                        else begin
                            nsp = base_ptr - 1;
                            npc = longint'($signed(stack_mem[base_ptr + 1]));
                            nfb = nb;
                            if (depth_now == 0) stop = 1; else ndepth = depth_now - 1;
                        end
                    end
                end else if (m == OPR_NEG || m == OPR_ODD) begin
                    if (stack_ptr < 1) bad = 1;
                    else begin
                        x = stack_mem[stack_ptr - 1];
                        wa[0] = stack_ptr - 1; nw = 1;
                        wd[0] = (m == OPR_NEG) ? 32'd0 - x : (x & 32'd1);
                    end
                end else if ($signed(m) >= OPR_ADD && $signed(m) <= OPR_GEQ) begin
                    if (stack_ptr < 2) bad = 1;
                    else begin
                        x = stack_mem[stack_ptr - 2];
                        y = stack_mem[stack_ptr - 1];
                        case (m)
                            OPR_ADD: v = x + y;
                            OPR_SUB: v = x - y;
                            OPR_MUL: v = x * y;
                            OPR_DIV, OPR_MOD: begin
                                if (y == 0) bad = 1;
                                else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF)
                                    v = (m == OPR_DIV) ? x : 32'd0;
                                else if (m == OPR_DIV) v = $signed(x) / $signed(y);
                                else v = $signed(x) % $signed(y);
                            end
                            OPR_EQL: v = {31'd0, x == y};
                            OPR_NEQ: v = {31'd0, x != y};
                            OPR_LSS: v = {31'd0, $signed(x) < $signed(y)};
                            OPR_LEQ: v = {31'd0, $signed(x) <= $signed(y)};
                            OPR_GTR: v = {31'd0, $signed(x) > $signed(y)};
                            default: v = {31'd0, $signed(x) >= $signed(y)};
                        endcase
                        wa[0] = stack_ptr - 2; wd[0] = v; nw = 1;
                        nsp = stack_ptr - 1;
                    end
                end
            end
            OP_LOD: begin
                if (stack_ptr >= STACK_WORDS || !walk_links(lev, b)) bad = 1;
                else begin
                    a = b - 1 + ms;
                    if (!in_range(a)) bad = 1;
                    else begin
                        wa[0] = stack_ptr; wd[0] = stack_mem[a]; nw = 1;
                        nsp = stack_ptr + 1;
                    end
                end
            end
            OP_STO: begin
                if (stack_ptr < 1 || !walk_links(lev, b)) bad = 1;
                else begin
                    a = b - 1 + ms;
                    if (!in_range(a)) bad = 1;
                    else begin
                        wa[0] = a; wd[0] = stack_mem[stack_ptr - 1]; nw = 1;
                        nsp = stack_ptr - 1;
                    end
                end
            end
            OP_CAL: begin
                if (depth_now >= CALL_DEPTH_MAX || stack_ptr + 2 >= STACK_WORDS
                    || !walk_links(lev, b)) bad = 1;
                else begin
                    wa[0] = stack_ptr;     wd[0] = b[31:0];
                    wa[1] = stack_ptr + 1; wd[1] = base_ptr[31:0];
                    wa[2] = stack_ptr + 2; wd[2] = npc[31:0];
                    nw = 3;
                    nfb = stack_ptr + 1;
                    npc = ms;
                    ndepth = depth_now + 1;
                end
            end
            OP_INC: begin
                a = stack_ptr + ms;
                if (a < 0 || a > STACK_WORDS) bad = 1; else nsp = a;
            end
            OP_JMP: npc = ms;
            OP_JPC, OP_OUT: begin
                if (stack_ptr < 1) bad = 1;
                else begin
                    nsp = stack_ptr - 1;
                    if (op == OP_OUT) begin
                        wrote = 1; outv = stack_mem[stack_ptr - 1];
                    end else if (stack_mem[stack_ptr - 1] == 0) npc = ms;
                end
            end
            default: ;
        endcase
        if (bad) begin
            if (commit) begin
                halted_now = 1; faulted_now = 1;
            end
            r = {pc_now[9:0], 1'b0, 32'd0, 1'b1, 1'b1};
            return r;
        end
        if (npc < 0 || npc >= PC_SPACE) stop = 1;
        if (commit) begin
            for (int k = 0; k < nw; k++) stack_mem[wa[k]] = wd[k];
            stack_ptr = nsp;
            base_ptr = nfb;
            depth_now = ndepth;
            pc_now = int'(npc & 64'd1023);
            halted_now = stop;
        end
        r = {npc[9:0], wrote, outv, stop, 1'b0};
        return r;
    endfunction

    task automatic send_item(input logic [3:0] op, input logic [3:0] lev,
                             input logic [31:0] m, input logic [31:0] rd,
                             input bit typed, input t_step_res typed_res);
        int gap;
        t_step_res r;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_level_diff <= lev;
        i_operand <= m;
        i_read_value <= rd;
        do @(posedge i_clk); while (!o_ready);
        r = predict_step(1'b1, op, lev, m, rd);
        pending_results = {pending_results, (typed ? typed_res : r)};
        items_sent++;
    endtask

    task automatic draw_item(output logic [3:0] op, output logic [3:0] lev,
                             output logic [31:0] m, output logic [31:0] rd);
        int kind;
        longint b, a;
        t_step_res r;
        for (int t = 0; t < 20; t++) begin
            kind = (stack_ptr > 800) ? 90 : $urandom_range(0, 99);
            lev = 4'($urandom_range(0, 15));
            m = $urandom;
            rd = $urandom;
            if (kind < 15) op = OP_LIT;
            else if (kind < 23) op = OP_IN;
            else if (kind < 46) begin
                op = OP_OPR; m = $urandom_range(1, 13);
            end else if (kind < 61) begin
                op = (kind < 54) ? OP_LOD : OP_STO;
                lev = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 1));
                if (walk_links(lev, b) && stack_ptr > 0) begin
                    a = longint'($urandom_range(0, int'(stack_ptr) - 1));
                    m = 32'(a - b + 1);
                end
            end else if (kind < 66) begin
                op = OP_CAL; lev = 4'($urandom_range(0, 2)); m = $urandom_range(0, 1000);
            end else if (kind < 73) begin
                op = OP_OPR; m = OPR_RET;
            end else if (kind < 79) begin
                op = OP_INC; m = 32'($urandom_range(0, 6) - 2);
            end else if (kind < 84) begin
                op = OP_JMP; m = $urandom_range(0, 1023);
            end else if (kind < 89) begin
                op = OP_JPC; m = $urandom_range(0, 1023);
            end else if (kind < 96) op = OP_OUT;
            else if (kind < 98) op = 4'($urandom_range(10, 15));
            else op = OP_OPR;
            r = predict_step(1'b0, op, lev, m, rd);
            if (!r.hlt) return;
        end
        op = OP_JMP; m = $urandom_range(0, 1000);
    endtask

    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                n = ((results_seen / 120) % 3 != 0) ? $urandom_range(0, 3) : 0;
                if (n > 0) begin
                    i_ready <= 1'b0;
                    repeat (n - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                i_ready <= 1'b1;
                do @(posedge i_clk); while (!o_valid);
            end
        end
    end

    always @(posedge i_clk) begin
        t_step_res e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result with nothing expected, pc=%0d", o_next_pc);
            end else begin
                e = pending_results.pop_front();
                if (o_next_pc !== e.pc || o_out_valid !== e.ov || o_out_value !== e.oval
                    || o_halted !== e.hlt || o_fault !== e.flt) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: result %0d exp pc=%0d ov=%b val=%h halt=%b fault=%b,",
                                 results_seen, e.pc, e.ov, e.oval, e.hlt, e.flt);
                        $display("       got pc=%0d ov=%b val=%h halt=%b fault=%b",
                                 o_next_pc, o_out_valid, o_out_value, o_halted, o_fault);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pcode_stack_machine_step_top verification failed");
            $finish;
        end
    end

    task automatic add_row(input logic [3:0] op, input logic [3:0] lev, input logic [31:0] m,
                           input logic [31:0] rd, input bit typed, input logic [9:0] pc,
                           input logic ov, input logic [31:0] oval);
        t_instr_row row;
        row = '{op, lev, m, rd, typed, pc, ov, oval};
        directed_rows = {directed_rows, row};
    endtask

    initial begin
        logic [3:0]  op, lev;
        logic [31:0] m, rd;
        int          ending;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_LIT;
        i_level_diff = '0;
        i_operand = '0;
        i_read_value = '0;
        rx_hold_req = 1'b0;
        tx_idle_on = 1'b1;
        foreach (stack_mem[k]) stack_mem[k] = '0;
        stack_ptr = 0; base_ptr = 1; depth_now = 0; pc_now = 0;
        halted_now = 0; faulted_now = 0;

        add_row(OP_LIT, 4'd15, 32'h7FFF_FFFF, 32'd0, 1, 10'd1, 0, 0);
        add_row(OP_LIT, 4'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1, 10'd2, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_ADD, 32'd0, 1, 10'd3, 0, 0);
        add_row(OP_IN, 4'd7, 32'd0, 32'h8000_0000, 0, 0, 0, 0);
        add_row(OP_LIT, 4'd0, 32'hFFFF_FFFF, 32'd0, 0, 0, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_DIV, 32'd0, 0, 0, 0, 0);
        add_row(OP_OUT, 4'd0, 32'd0, 32'd0, 1, 10'd7, 1, 32'h8000_0000);
        add_row(OP_LIT, 4'd0, 32'd7, 32'd0, 0, 0, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_MOD, 32'd0, 0, 0, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_ODD, 32'd0, 0, 0, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_NEG, 32'd0, 0, 0, 0, 0);
        add_row(OP_LIT, 4'd0, 32'd3, 32'd0, 0, 0, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_MUL, 32'd0, 0, 0, 0, 0);
        add_row(OP_CAL, 4'd0, 32'd40, 32'd0, 1, 10'd40, 0, 0);
        add_row(OP_INC, 4'd0, 32'd3, 32'd0, 0, 0, 0, 0);
        add_row(OP_LOD, 4'd1, 32'd1, 32'd0, 0, 0, 0, 0);
        add_row(OP_STO, 4'd0, 32'd4, 32'd0, 0, 0, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_UNUSED, 32'd0, 1, 10'd44, 0, 0);
        add_row(OP_UNUSED, 4'd0, 32'd0, 32'd0, 1, 10'd45, 0, 0);
        add_row(OP_JPC, 4'd0, 32'd100, 32'd0, 0, 0, 0, 0);
        add_row(OP_JMP, 4'd0, 32'd60, 32'd0, 1, 10'd60, 0, 0);
        add_row(OP_OPR, 4'd0, OPR_RET, 32'd0, 1, 10'd14, 0, 0);
        add_row(OP_LIT, 4'd0, 32'd0, 32'd0, 0, 0, 0, 0);
        add_row(OP_JPC, 4'd0, 32'd30, 32'd0, 1, 10'd30, 0, 0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].op, directed_rows[k].lev, directed_rows[k].m,
                      directed_rows[k].rd, directed_rows[k].typed,
                      {directed_rows[k].pc, directed_rows[k].ov, directed_rows[k].oval,
                       2'b00});

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            tx_idle_on = (k / 150) % 3 != 1;
            if (k == 600) rx_hold_req = 1'b1;
            if (k == 1200) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            draw_item(op, lev, m, rd);
            send_item(op, lev, m, rd, 0, '0);
        end

        ending = $urandom_range(0, 3);
        case (ending)
            0, 1: begin
                send_item(OP_LIT, 4'd0, 32'd5, 32'd0, 0, '0);
                send_item(OP_LIT, 4'd0, 32'd0, 32'd0, 0, '0);
                send_item(OP_OPR, 4'd0, ending == 0 ? OPR_DIV : OPR_MOD, 32'd0, 0, '0);
            end
            2: begin
                send_item(OP_JMP, 4'd0, 32'd1023, 32'd0, 0, '0);
                send_item(OP_LIT, 4'd0, 32'd9, 32'd0, 0, '0);
            end
            default: begin
                send_item(OP_INC, 4'd0, 32'(-stack_ptr), 32'd0, 0, '0);
                send_item(OP_OUT, 4'd0, 32'd0, 32'd0, 0, '0);
            end
        endcase
        repeat (4) send_item(4'($urandom_range(0, 9)), 4'd0, $urandom, $urandom, 0, '0);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        $display("Sent %0d instructions (directed table, random programs, halting case %0d),",
                 items_sent, ending);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0 && results_seen == items_sent) begin
            $display("pcode_stack_machine_step_top verification clean");
        end else begin
            $display("pcode_stack_machine_step_top verification failed");
        end
        $finish;
    end

endmodule
